@@ rtl/core/fnvks_pkg.sv @@
// Package: shared constants and types for the FNV-1a hashed key set.
`timescale 1ns / 1ps
package fnvks_pkg;
    localparam int CAPACITY = 1024;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
    localparam logic [63:0] FNV_MUL = 64'd1099511628211;

    typedef enum logic [1:0] {
        FN_HASH  = 2'd0,
        FN_INS   = 2'd1,
        FN_CHK   = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    typedef struct packed {
        logic load;       // latch byte and func
        logic mul_step;   // advance multiplier
        logic hash_done;  // commit running hash (func 0) or reset basis
        logic probe_rd;   // issue table read at probe index
        logic probe_nxt;  // step probe index
        logic do_insert;  // write key at probe index
        logic do_clear;   // start/continue clear sweep
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic slot_vld;
        logic key_match;
        logic probe_wrap;
        logic at_cap;
        logic clr_done;
    } t_stat;
endpackage

@@ rtl/core/fnvks_datapath.sv @@
// Datapath: FNV multiply, probe address, key table and valid marks.
`timescale 1ns / 1ps
module fnvks_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fnvks_pkg::t_cmd             i_cmd,
    input  logic [1:0]                  i_func,
    input  logic [7:0]                  i_byte,
    output fnvks_pkg::t_stat            o_stat,
    output logic [1:0]                  o_func,
    output logic [63:0]                 o_hash,
    output logic [fnvks_pkg::CNT_W-1:0] o_count
);
    import fnvks_pkg::*;

    logic [63:0] r_run, r_h, r_acc, r_mcand;
    logic [63:0] n_part;
    logic [1:0]  r_func;
    logic [1:0]  r_mstep;
    logic [IDX_W-1:0] r_idx, r_start;
    logic [IDX_W-1:0] r_cidx;
    logic [CNT_W-1:0] r_cnt;
    logic        r_vld [CAPACITY];
    logic [63:0] r_mem [CAPACITY];
    logic [63:0] r_rd;
    logic        r_rvld;
    logic [IDX_W-1:0] n_idx;

    // 64x64 low product in four 64x16 partial products
    assign n_part = r_mcand * {48'd0, FNV_MUL[16*r_mstep +: 16]};
    assign n_idx = (r_idx == IDX_W'(CAPACITY - 1)) ? '0 : r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= FNV_BASIS;
            r_cnt <= '0;
            r_mstep <= '0;
            r_cidx <= '0;
        end else begin
            if (i_cmd.load) begin
                r_func <= i_func;
                r_mcand <= r_run ^ {56'd0, i_byte};
                r_acc <= '0;
                r_mstep <= '0;
            end else if (i_cmd.mul_step) begin
                r_acc <= r_acc + (n_part << (16 * r_mstep));
                r_mstep <= r_mstep + 1'b1;
                if (r_mstep == 2'd3) r_h <= r_acc + (n_part << 48);
            end
            if (i_cmd.hash_done) begin
                r_run <= (r_func == FN_HASH) ? r_h : FNV_BASIS;
                r_idx <= r_h[IDX_W-1:0];
                r_start <= r_h[IDX_W-1:0];
            end
            if (i_cmd.probe_nxt) r_idx <= n_idx;
            if (i_cmd.do_insert) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.do_clear) begin
                r_cnt <= '0;
                r_run <= FNV_BASIS;
                r_cidx <= (r_cidx == IDX_W'(CAPACITY - 1)) ? '0 : r_cidx + 1'b1;
            end
        end
    end

    // valid marks cleared one slot a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_clear) r_vld[r_cidx] <= 1'b0;
        else if (i_cmd.do_insert) r_vld[r_idx] <= 1'b1;
        if (i_cmd.do_insert) r_mem[r_idx] <= r_h;
        if (i_cmd.probe_rd) begin
            r_rd <= r_mem[r_idx];
            r_rvld <= r_vld[r_idx];
        end
    end

    assign o_stat.mul_done   = (r_mstep == 2'd3) && i_cmd.mul_step;
    assign o_stat.slot_vld   = r_rvld;
    assign o_stat.key_match  = r_rd == r_h;
    assign o_stat.probe_wrap = n_idx == r_start;
    assign o_stat.at_cap     = r_cnt >= CNT_W'(CAPACITY);
    assign o_stat.clr_done   = r_cidx == IDX_W'(CAPACITY - 1);
    assign o_func  = r_func;
    assign o_hash  = r_h;
    assign o_count = r_cnt;
endmodule

@@ rtl/core/fnvks_ctrl.sv @@
// Controller: sequences hashing, probing, insertion and result hand-off.
`timescale 1ns / 1ps
module fnvks_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic [1:0]       i_func,
    input  fnvks_pkg::t_stat i_stat,
    input  logic [1:0]       i_lfunc,
    input  logic             i_out_fire,
    output fnvks_pkg::t_cmd  o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_flags
);
    import fnvks_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_DONE = 7'b0000100,
        S_RD   = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_CLR  = 7'b1000000
    } t_state;

    t_state r_st, n_st;
    logic [2:0] r_fl, n_fl;

    always_comb begin
        o_cmd = '0;
        n_st = r_st;
        n_fl = r_fl;
        unique case (r_st)
            S_IDLE: if (i_in_fire) begin
                if (t_func'(i_func) == FN_CLEAR) n_st = S_CLR;
                else begin
                    o_cmd.load = 1'b1;
                    n_st = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_done) n_st = S_DONE;
            end
            S_DONE: begin
                o_cmd.hash_done = 1'b1;
                n_st = (t_func'(i_lfunc) == FN_HASH) ? S_IDLE : S_RD;
            end
            S_RD: begin
                o_cmd.probe_rd = 1'b1;
                n_st = S_CMP;
            end
            S_CMP: begin
                n_st = S_OUT;
                priority if (!i_stat.slot_vld) begin
                    if (t_func'(i_lfunc) == FN_INS && !i_stat.at_cap) begin
                        o_cmd.do_insert = 1'b1;
                        n_fl = 3'b010;
                    end else if (t_func'(i_lfunc) == FN_INS) n_fl = 3'b100;
                    else n_fl = 3'b000;
                end else if (i_stat.key_match) n_fl = 3'b001;
                else if (i_stat.probe_wrap)
                    n_fl = (t_func'(i_lfunc) == FN_INS) ? 3'b100 : 3'b000;
                else begin
                    o_cmd.probe_nxt = 1'b1;
                    n_st = S_RD;
                end
            end
            S_OUT: if (i_out_fire) n_st = S_IDLE;
            S_CLR: begin
                o_cmd.do_clear = 1'b1;
                if (i_stat.clr_done) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_fl <= '0;
        end else begin
            r_st <= n_st;
            r_fl <= n_fl;
        end
    end

    assign o_in_ready  = r_st == S_IDLE;
    assign o_out_valid = r_st == S_OUT;
    assign o_flags     = r_fl;

`ifndef SYNTH
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state");
    a_fl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(r_fl)) else $error("flags");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_fire |=> o_out_valid && $stable(r_fl)) else $error("hold");
`endif
endmodule

@@ rtl/core/fnv1a_hashed_key_set.sv @@
// Top level: FNV-1a hashed key set with stream ports.
// Hash byte: load, 64x16 partial-product multiply, commit. A key end adds a table
// read and compare per probe step plus result hand-off. Throughput: one request at a time.
// Reset: synchronous active low; count and running hash cleared, then a
// sweep over all 1024 slots clears the valid marks. A clear request runs the same sweep.
`timescale 1ns / 1ps
module fnv1a_hashed_key_set (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // key_byte
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // present, added, full_res, stored_count[10:0], key_hash[63:0], 0
);
    import fnvks_pkg::*;

    t_cmd cmd;
    t_stat stat;
    logic [1:0] lfunc;
    logic [63:0] hash;
    logic [CNT_W-1:0] cnt;
    logic [2:0] fl;

    fnvks_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready), .i_func(s_axis_tuser),
        .i_stat(stat), .i_lfunc(lfunc), .i_out_fire(m_axis_tvalid && m_axis_tready),
        .o_cmd(cmd), .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_flags(fl)
    );

    fnvks_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_func(s_axis_tuser),
        .i_byte(s_axis_tdata), .o_stat(stat), .o_func(lfunc), .o_hash(hash),
        .o_count(cnt)
    );

    assign m_axis_tdata = {2'd0, hash, 11'(cnt), fl[2], fl[1], fl[0]};
endmodule
